FILE: design/chi_pkg.sv
// Shared types and constants for the chained hash index.
// No dependencies.
package chi_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_ERASE  = 3'd2;
    localparam logic [2:0] REQ_REWIND = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic ADDR_BUCKET_MASK = 1'b0;
    localparam logic ADDR_ENTRY_LIMIT = 1'b1;

    localparam logic [9:0]  MASK_RESET  = 10'd1023;
    localparam logic [10:0] LIMIT_RESET = 11'd1024;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CLEAR  = 9'b000000010,
        ST_HEAD   = 9'b000000100,
        ST_HWAIT  = 9'b000001000,
        ST_ENTRY  = 9'b000010000,
        ST_EWAIT  = 9'b000100000,
        ST_CHECK  = 9'b001000000,
        ST_WRITE  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic found;
        logic [31:0] value_out;
        logic status;
    } result_t;

endpackage

FILE: design/chi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/chained_hash_index_unit.sv
// Top level of the chained hash index: sequencer, config registers, RAMs.
// Depends on chi_pkg and chi_ram.
//
// Usage:
//  - Input channel s_valid/s_ready carries s_req_type, s_key, s_value.
//    Result channel m_valid/m_ready carries m_found, m_value_out, m_status.
//  - APB port writes bucket_mask (addr 0) and entry_limit (addr 4).
//  - One item at a time. The chain walk is set by the single read port of
//    the entry RAMs: each chain entry passes through an address, a read
//    wait and a compare state. A walk reads the bucket head, visits chain
//    entries until a hit or the chain ends, then writes and presents the
//    result; rewind and unknown requests go straight to the result, clear
//    sweeps every bucket first. s_ready returns the cycle after the result
//    is taken.
//  - Walks stop after ENTRIES+1 entries, so a looping chain still ends.
//  - After reset the bucket-head RAM is swept to zero, one bucket per cycle,
//    s_ready low meanwhile; config writes still work.
//  - The result is held in an output register until m_ready; s_ready stays
//    low until it is taken. Erase zeroes the entry's key, value and link.
module chained_hash_index_unit #(
    parameter int ENTRIES = 1024,
    parameter int BUCKETS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic signed [63:0] s_key,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [31:0] m_value_out,
    output logic        m_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES + 1);   // entry number, 0 = none
    localparam int AW = $clog2(ENTRIES);       // RAM address = number - 1
    localparam int SW = $clog2(ENTRIES + 2);
    localparam logic [EW-1:0] ENT_MAX = EW'(ENTRIES);

    chi_pkg::state_t state_reg, state_next;
    logic [9:0]  mask_reg;
    logic [10:0] limit_reg;
    logic [EW-1:0] free_reg, free_next;
    logic [BW-1:0] sweep_reg, sweep_next;
    logic [2:0]  req_reg, req_next;
    logic [63:0] key_reg, key_next;
    logic [31:0] val_reg, val_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [EW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [EW-1:0] curlink_reg, curlink_next;
    chi_pkg::result_t res_reg, res_next;

    // RAM ports
    logic          h_we;
    logic [BW-1:0] h_waddr, h_raddr;
    logic [EW-1:0] h_wdata, h_rdata;
    logic          k_we, v_we, l_we;
    logic [AW-1:0] e_waddr, l_waddr, e_raddr;
    logic [63:0]   k_wdata, k_rdata;
    logic [31:0]   v_wdata, v_rdata;
    logic [EW-1:0] l_wdata, l_rdata;

    chi_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_heads (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata));
    chi_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_keys (
        .aclk(aclk), .we(k_we), .waddr(e_waddr), .wdata(k_wdata),
        .raddr(e_raddr), .rdata(k_rdata));
    chi_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_vals (
        .aclk(aclk), .we(v_we), .waddr(e_waddr), .wdata(v_wdata),
        .raddr(e_raddr), .rdata(v_rdata));
    chi_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_links (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(e_raddr), .rdata(l_rdata));

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[2])
            chi_pkg::ADDR_BUCKET_MASK: prdata = {22'd0, mask_reg};
            chi_pkg::ADDR_ENTRY_LIMIT: prdata = {21'd0, limit_reg};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= chi_pkg::MASK_RESET;
            limit_reg <= chi_pkg::LIMIT_RESET;
        end else if (cfg_wr && paddr[1:0] == 2'd0) begin
            case (paddr[2])
                chi_pkg::ADDR_BUCKET_MASK: mask_reg  <= pwdata[9:0];
                chi_pkg::ADDR_ENTRY_LIMIT: limit_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // effective limit and bucket (bucket wraps modulo BUCKETS)
    logic [16:0] limit_eff;
    logic [31:0] bmasked;
    logic [BW-1:0] s_bkt;
    assign limit_eff = (17'(limit_reg) > 17'(ENTRIES)) ? 17'(ENTRIES) : 17'(limit_reg);
    assign bmasked   = 32'(s_key[9:0] & mask_reg);
    assign s_bkt     = BW'(bmasked % BUCKETS);

    logic cur_valid, key_hit;
    assign cur_valid = (cur_reg != '0) && (cur_reg <= ENT_MAX)
                       && (32'(steps_reg) <= 32'(ENTRIES));
    assign key_hit   = (k_rdata == key_reg);

    assign s_ready = (state_reg == chi_pkg::ST_IDLE);
    assign m_valid = (state_reg == chi_pkg::ST_OUT);
    assign m_found     = res_reg.found;
    assign m_value_out = res_reg.value_out;
    assign m_status    = res_reg.status;

    always_comb begin
        state_next = state_reg;
        free_next  = free_reg;
        sweep_next = sweep_reg;
        req_next   = req_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        bkt_next   = bkt_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        curlink_next = curlink_reg;
        res_next   = res_reg;
        h_we = 1'b0; h_waddr = bkt_reg; h_wdata = '0; h_raddr = bkt_reg;
        k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
        e_waddr = AW'(cur_reg - 1'b1); l_waddr = e_waddr;
        e_raddr = AW'(cur_reg - 1'b1);
        k_wdata = key_reg; v_wdata = val_reg; l_wdata = '0;
        case (state_reg)
            chi_pkg::ST_CLEAR: begin
                h_we = 1'b1; h_waddr = sweep_reg; h_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (32'(sweep_reg) == BUCKETS - 1) begin
                    sweep_next = '0;
                    state_next = req_reg == chi_pkg::REQ_CLEAR ?
                                 chi_pkg::ST_OUT : chi_pkg::ST_IDLE;
                end
            end
            chi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_req_type;
                    key_next = s_key;
                    val_next = s_value;
                    bkt_next = s_bkt;
                    res_next = '0;
                    prev_next = '0;
                    steps_next = '0;
                    case (s_req_type)
                        chi_pkg::REQ_INSERT, chi_pkg::REQ_LOOKUP,
                        chi_pkg::REQ_ERASE: state_next = chi_pkg::ST_HEAD;
                        chi_pkg::REQ_REWIND: begin
                            free_next  = EW'(1);
                            state_next = chi_pkg::ST_OUT;
                        end
                        chi_pkg::REQ_CLEAR: begin
                            free_next  = EW'(1);
                            state_next = chi_pkg::ST_CLEAR;
                        end
                        default: state_next = chi_pkg::ST_OUT;
                    endcase
                end
            end
            chi_pkg::ST_HEAD:  state_next = chi_pkg::ST_HWAIT;
            chi_pkg::ST_HWAIT: begin
                cur_next   = h_rdata;
                state_next = chi_pkg::ST_ENTRY;
            end
            chi_pkg::ST_ENTRY: begin
                if (cur_valid) state_next = chi_pkg::ST_EWAIT;
                else           state_next = chi_pkg::ST_WRITE;
            end
            chi_pkg::ST_EWAIT: state_next = chi_pkg::ST_CHECK;
            chi_pkg::ST_CHECK: begin
                curlink_next = l_rdata;
                if (key_hit) begin
                    res_next.found = 1'b1;
                    if (req_reg == chi_pkg::REQ_LOOKUP) res_next.value_out = v_rdata;
                    // erased entry drops its link here; the write slot frees up
                    // for the predecessor's link
                    if (req_reg == chi_pkg::REQ_ERASE) begin
                        l_we = 1'b1; l_wdata = '0;
                    end
                    state_next = chi_pkg::ST_WRITE;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = l_rdata;
                    steps_next = steps_reg + 1'b1;
                    state_next = chi_pkg::ST_ENTRY;
                end
            end
            chi_pkg::ST_WRITE: begin
                state_next = chi_pkg::ST_OUT;
                case (req_reg)
                    chi_pkg::REQ_INSERT: begin
                        if (res_reg.found) begin
                            v_we = 1'b1;
                        end else if (17'(free_reg) <= limit_eff) begin
                            e_waddr = AW'(free_reg - 1'b1);
                            l_waddr = e_waddr;
                            k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
                            l_wdata = h_rdata;
                            h_we = 1'b1; h_wdata = free_reg;
                            free_next = free_reg + 1'b1;
                        end else begin
                            res_next.status = 1'b1;
                        end
                    end
                    chi_pkg::REQ_ERASE: begin
                        if (res_reg.found) begin
                            if (prev_reg == '0) begin
                                h_we = 1'b1; h_wdata = curlink_reg;
                            end else begin
                                l_we = 1'b1; l_waddr = AW'(prev_reg - 1'b1);
                                l_wdata = curlink_reg;
                            end
                            k_we = 1'b1; k_wdata = '0;
                            v_we = 1'b1; v_wdata = '0;
                        end
                    end
                    default: ;
                endcase
            end
            chi_pkg::ST_OUT: begin
                if (m_ready) state_next = chi_pkg::ST_IDLE;
            end
            default: state_next = chi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chi_pkg::ST_CLEAR;
            free_reg  <= EW'(1);
            sweep_reg <= '0;
            req_reg   <= '0;
        end else begin
            state_reg <= state_next;
            free_reg  <= free_next;
            sweep_reg <= sweep_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        val_reg   <= val_next;
        bkt_reg   <= bkt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        curlink_reg <= curlink_next;
        res_reg   <= res_next;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while result pending");
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(free_reg) <= ENTRIES + 1) else $error("allocator overrun");
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_full_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_found && m_value_out == '0)
        else $error("full with found");
`endif
endmodule

FILE: sim/chained_hash_index_unit_test.sv
// Testbench for chained_hash_index_unit: random and directed requests checked
// against a scoreboard that predicts every result. Depends on chi_pkg and the RTL.
module chained_hash_index_unit_test;

    localparam int NUM_ENTRIES = 1024;
    localparam int NUM_BUCKETS = 1024;
    localparam int CYCLE_LIMIT = 20000000;

    // Predicts each item's result from its own copy of the table and holds
    // the expected results in acceptance order.
    class hash_index_scoreboard;
        logic [9:0]  bucket_mask;
        logic [10:0] entry_limit;
        logic [10:0] heads [NUM_BUCKETS];
        logic [63:0] keys [NUM_ENTRIES + 1];
        logic [31:0] vals [NUM_ENTRIES + 1];
        logic [10:0] links [NUM_ENTRIES + 1];
        int          next_free;
        chi_pkg::result_t awaited [$];
        int          errors;

        function void wipe();
            foreach (heads[i]) heads[i] = '0;
            for (int i = 0; i <= NUM_ENTRIES; i++) begin
                keys[i] = '0;
                vals[i] = '0;
                links[i] = '0;
            end
            next_free = 1;
        endfunction

        function void note_input(logic [2:0] req, logic [63:0] key, logic [31:0] val);
            int      b;
            int      j;
            int      prev;
            int      steps;
            int      cap;
            chi_pkg::result_t r;
            r = '0;
            b = int'(key[9:0] & bucket_mask) % NUM_BUCKETS;
            cap = (entry_limit > NUM_ENTRIES) ? NUM_ENTRIES : int'(entry_limit);
            case (req)
                chi_pkg::REQ_INSERT, chi_pkg::REQ_LOOKUP, chi_pkg::REQ_ERASE: begin
                    prev = 0;
                    steps = 0;
                    j = (heads[b] <= NUM_ENTRIES) ? int'(heads[b]) : 0;
                    // bounded walk: a chain may loop after a rewind
                    while (j != 0 && steps <= NUM_ENTRIES && keys[j] != key) begin
                        prev = j;
                        j = (links[j] <= NUM_ENTRIES) ? int'(links[j]) : 0;
                        steps++;
                    end
                    if (steps > NUM_ENTRIES) j = 0;
                    if (req == chi_pkg::REQ_INSERT) begin
                        if (j != 0) begin
                            vals[j] = val;
                            r.found = 1'b1;
                        end else if (next_free >= 1 && next_free <= cap) begin
                            j = next_free;
                            next_free++;
                            links[j] = heads[b];
                            heads[b] = 11'(j);
                            keys[j] = key;
                            vals[j] = val;
                        end else begin
                            r.status = 1'b1;
                        end
                    end else if (req == chi_pkg::REQ_LOOKUP) begin
                        if (j != 0) begin
                            r.found = 1'b1;
                            r.value_out = vals[j];
                        end
                    end else if (j != 0) begin
                        if (prev == 0) heads[b] = links[j];
                        else links[prev] = links[j];
                        keys[j] = '0;
                        vals[j] = '0;
                        links[j] = '0;
                        r.found = 1'b1;
                    end
                end
                chi_pkg::REQ_REWIND: next_free = 1;
                chi_pkg::REQ_CLEAR: wipe();
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic f, logic [31:0] v, logic s);
            chi_pkg::result_t e;
            if (awaited.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (f !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, f);
                errors++;
            end
            if (v !== e.value_out) begin
                $error("value_out: expected %h, got %h", e.value_out, v);
                errors++;
            end
            if (s !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, s);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_req_type = chi_pkg::REQ_LOOKUP;
    logic signed [63:0] s_key = '0;
    logic [31:0]        s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic [31:0]        m_value_out;
    logic               m_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    chained_hash_index_unit #(.ENTRIES(NUM_ENTRIES), .BUCKETS(NUM_BUCKETS)) dut (.*);

    always #6 aclk = ~aclk;

    hash_index_scoreboard table_sb = new();
    logic [63:0] key_pool [24];
    bit          no_idle = 1'b0;    // sender and receiver run flat out
    int          hold_cycles = 0;   // receiver back-pressure request
    int          cycle_count = 0;

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: checks results sampled at the edge, then picks next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            table_sb.check_result(m_found, m_value_out, m_status);
        if (hold_cycles > 0) begin
            // long hold-off so the block fills and stalls its input
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 36);
        end
    end

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(logic addr_sel, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {addr_sel, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr_sel == chi_pkg::ADDR_BUCKET_MASK) table_sb.bucket_mask = data[9:0];
        else table_sb.entry_limit = data[10:0];
    endtask

    // Offers one item and waits until it is accepted; unless no_idle is set,
    // it may then drop valid and idle before returning.
    task automatic send_item(logic [2:0] req, logic [63:0] key, logic [31:0] val);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_key <= key;
        s_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        table_sb.note_input(req, key, val);
        if (!no_idle && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (table_sb.awaited.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_key();
        if ($urandom_range(99) < 85) return key_pool[$urandom_range(23)];
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [2:0] pick_req();
        int r;
        r = $urandom_range(99);
        if (r < 42) return chi_pkg::REQ_INSERT;
        if (r < 72) return chi_pkg::REQ_LOOKUP;
        if (r < 92) return chi_pkg::REQ_ERASE;
        if (r < 95) return chi_pkg::REQ_REWIND;
        if (r < 96) return chi_pkg::REQ_CLEAR;
        return 3'($urandom_range(5, 7));   // undefined codes
    endfunction

    task automatic random_phase(logic [9:0] mask, logic [10:0] limit, int count);
        reg_write(chi_pkg::ADDR_BUCKET_MASK, 32'(mask));
        reg_write(chi_pkg::ADDR_ENTRY_LIMIT, 32'(limit));
        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom(), $urandom()};
            // some keys share low bits so chains collide
            if (i % 3 == 0) key_pool[i][9:0] = 10'(i);
        end
        for (int n = 0; n < count; n++)
            send_item(pick_req(), pick_key(), $urandom());
        drain();
    endtask

    initial begin
        logic [63:0] kmax;
        logic [63:0] kmin;
        kmax = 64'h7FFF_FFFF_FFFF_FFFF;
        kmin = 64'h8000_0000_0000_0000;
        table_sb.bucket_mask = chi_pkg::MASK_RESET;
        table_sb.entry_limit = chi_pkg::LIMIT_RESET;
        table_sb.wipe();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset config, extreme keys and values, every request.
        send_item(chi_pkg::REQ_INSERT, 64'd0, 32'hFFFF_FFFF);
        send_item(chi_pkg::REQ_INSERT, kmax, 32'h0);
        send_item(chi_pkg::REQ_INSERT, kmin, 32'hA5A5_5A5A);
        send_item(chi_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        send_item(chi_pkg::REQ_LOOKUP, 64'd0, 32'h0);
        send_item(chi_pkg::REQ_LOOKUP, kmax, 32'h0);
        send_item(chi_pkg::REQ_LOOKUP, kmin, 32'h0);
        send_item(chi_pkg::REQ_INSERT, kmax, 32'hDEAD_BEEF);       // update
        send_item(chi_pkg::REQ_LOOKUP, kmax, 32'h0);
        send_item(chi_pkg::REQ_LOOKUP, 64'h0000_0000_0000_0400, 32'h0);  // same bucket
        send_item(chi_pkg::REQ_ERASE, kmin, 32'h0);
        send_item(chi_pkg::REQ_ERASE, kmin, 32'h0);                // already gone
        send_item(chi_pkg::REQ_LOOKUP, kmin, 32'h0);
        send_item(3'd5, kmax, 32'hFFFF_FFFF);
        send_item(3'd6, 64'd0, 32'h0);
        send_item(3'd7, kmin, 32'h1);
        send_item(chi_pkg::REQ_REWIND, 64'd0, 32'h0);
        send_item(chi_pkg::REQ_INSERT, 64'd1023, 32'h55);          // reuses first entry
        send_item(chi_pkg::REQ_LOOKUP, 64'd0, 32'h0);
        send_item(chi_pkg::REQ_CLEAR, 64'd0, 32'h0);
        send_item(chi_pkg::REQ_LOOKUP, 64'd1023, 32'h0);
        drain();

        // Limit zero: always full.
        reg_write(chi_pkg::ADDR_ENTRY_LIMIT, 32'd0);
        send_item(chi_pkg::REQ_INSERT, kmax, 32'h7);
        send_item(chi_pkg::REQ_LOOKUP, kmax, 32'h0);
        drain();

        // Single bucket, looping chains after rewinds.
        reg_write(chi_pkg::ADDR_BUCKET_MASK, 32'd0);
        reg_write(chi_pkg::ADDR_ENTRY_LIMIT, 32'd2);
        send_item(chi_pkg::REQ_CLEAR, 64'd0, 32'h0);
        send_item(chi_pkg::REQ_INSERT, 64'd11, 32'h1);
        send_item(chi_pkg::REQ_INSERT, 64'd22, 32'h2);
        send_item(chi_pkg::REQ_INSERT, 64'd33, 32'h3);             // full
        send_item(chi_pkg::REQ_REWIND, 64'd0, 32'h0);
        send_item(chi_pkg::REQ_INSERT, 64'd44, 32'h4);             // chain loops
        send_item(chi_pkg::REQ_LOOKUP, 64'd99, 32'h0);
        send_item(chi_pkg::REQ_ERASE, 64'd99, 32'h0);
        send_item(chi_pkg::REQ_LOOKUP, 64'd22, 32'h0);
        drain();

        random_phase(10'd0, 11'd1, 30);
        hold_cycles = 400;
        random_phase(10'd3, 11'd16, 150);
        no_idle = 1'b1;
        random_phase(10'd15, 11'd64, 120);
        no_idle = 1'b0;
        random_phase(10'd1023, 11'd2047, 120);
        random_phase(10'd0, 11'd8, 60);
        random_phase(10'd255, 11'd200, 170);
        random_phase(10'd1023, 11'd1024, 40);

        if (table_sb.errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
